// ===== design/u64p_pkg.sv =====
package u64p_pkg;

	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_ZERO   = 5'b00010,
		PH_DIGITS = 5'b00100,
		PH_SUFFIX = 5'b01000,
		PH_ERROR  = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		RDX_2  = 2'd0,
		RDX_8  = 2'd1,
		RDX_10 = 2'd2,
		RDX_16 = 2'd3
	} radix_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_SYNTAX   = 2'd2
	} status_t;

	typedef struct packed {
		phase_t      phase;
		radix_t      radix;
		logic [63:0] acc;
		status_t     err;
	} parse_state_t;

	localparam parse_state_t STATE_CLEAR = '{
		phase: PH_START, radix: RDX_10, acc: 64'd0, err: ST_OK
	};

	localparam logic [63:0] DEC_LIMIT = 64'h1999_9999_9999_9999;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_O  = 8'h4F;
	localparam logic [7:0] CH_LO_O  = 8'h6F;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_UP_U  = 8'h55;
	localparam logic [7:0] CH_LO_U  = 8'h75;

	// 16 for a byte that is no hex digit
	function automatic logic [4:0] digit_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= CH_0 && c <= CH_9)
			v = 5'(c - CH_0);
		else if (c >= CH_UP_A && c <= CH_UP_F)
			v = 5'(c - CH_UP_A) + 5'd10;
		else if (c >= CH_LO_A && c <= CH_LO_F)
			v = 5'(c - CH_LO_A) + 5'd10;
		return v;
	endfunction

	function automatic logic [4:0] radix_base(input radix_t r);
		logic [4:0] b;
		case (r)
			RDX_2:   b = 5'd2;
			RDX_8:   b = 5'd8;
			RDX_16:  b = 5'd16;
			default: b = 5'd10;
		endcase
		return b;
	endfunction

endpackage

// ===== design/unsigned_64bit_number_text_parser.sv =====
// Result: registered when a string's final input transaction leaves the input
// register, which holds that transaction while an untaken result fills the output.
// Throughput: one input transaction per cycle but for that wait; the parse state
// updates in one combinational step between the input and result registers.
// Reset: arst_n clears the input and output valid flags and the parse state.
module unsigned_64bit_number_text_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tuser,   // [0] no_char
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata    // [63:0] number, [65:64] status, [71:66] zero
);
	import u64p_pkg::*;

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         no_char_s1;
	logic         last_s1;
	logic         s1_go;
	logic         out_free;
	parse_state_t st_q;
	parse_state_t st_nxt;
	logic         out_valid_q;
	logic [63:0]  number_q;
	status_t      status_q;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_go         = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1    <= s_axis_tdata;
			no_char_s1 <= s_axis_tuser;
			last_s1    <= s_axis_tlast;
		end
	end

	u64p_step u_step (
		.cur       (st_q),
		.char_code (char_s1),
		.no_char   (no_char_s1),
		.nxt       (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_CLEAR;
		end else if (s1_go) begin
			st_q <= last_s1 ? STATE_CLEAR : st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			number_q <= (st_nxt.err == ST_OK) ? st_nxt.acc : 64'd0;
			status_q <= st_nxt.err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, status_q, number_q};

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (status_q != ST_OK) |-> number_q == 64'd0)
		else $error("error result carries a nonzero number");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && last_s1 |=> (st_q == STATE_CLEAR) && m_axis_tvalid)
		else $error("end of string did not clear state or raise result");

	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_ERROR) |-> (st_q.err != ST_OK))
		else $error("error phase without error code");

	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase != PH_ERROR) |-> (st_q.err == ST_OK))
		else $error("error code set outside error phase");

	a_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_START || st_q.phase == PH_ZERO) |-> st_q.acc == 64'd0)
		else $error("accumulator nonzero before digits");

endmodule

// ===== design/u64p_step.sv =====
module u64p_step (
	input  u64p_pkg::parse_state_t cur,
	input  logic [7:0]             char_code,
	input  logic                   no_char,
	output u64p_pkg::parse_state_t nxt
);
	import u64p_pkg::*;

	radix_t      rdx;
	logic [4:0]  dval;
	logic        in_base;
	logic        mul_ovf;
	logic [63:0] prod;
	logic [64:0] sum;
	logic        is_u;
	logic        suffix_ok;
	logic        run_digit;
	status_t     fail_code;
	logic        do_fail;

	always_comb begin
		unique case (cur.phase)
			PH_START: rdx = RDX_10;
			PH_ZERO:  rdx = RDX_8;
			default:  rdx = cur.radix;
		endcase
	end

	assign dval    = digit_value(char_code);
	assign in_base = dval < radix_base(rdx);
	assign is_u    = (char_code == CH_LO_U) || (char_code == CH_UP_U);
	assign suffix_ok = is_u && ((rdx == RDX_10) || ((rdx == RDX_8) && (cur.acc == 64'd0)));

	always_comb begin
		case (rdx)
			RDX_2: begin
				mul_ovf = cur.acc[63];
				prod    = {cur.acc[62:0], 1'b0};
			end
			RDX_8: begin
				mul_ovf = |cur.acc[63:61];
				prod    = {cur.acc[60:0], 3'b000};
			end
			RDX_16: begin
				mul_ovf = |cur.acc[63:60];
				prod    = {cur.acc[59:0], 4'b0000};
			end
			default: begin
				mul_ovf = cur.acc > DEC_LIMIT;
				prod    = {cur.acc[60:0], 3'b000} + {cur.acc[62:0], 1'b0};
			end
		endcase
	end

	assign sum = {1'b0, prod} + 65'(dval);

	always_comb begin
		nxt       = cur;
		run_digit = 1'b0;
		do_fail   = 1'b0;
		fail_code = ST_SYNTAX;
		if (!no_char) begin
			unique case (cur.phase)
				PH_START: begin
					if (char_code == CH_0) begin
						nxt.phase = PH_ZERO;
						nxt.radix = RDX_8;
						nxt.acc   = 64'd0;
					end else begin
						run_digit = 1'b1;
					end
				end
				PH_ZERO: begin
					nxt.phase = PH_DIGITS;
					if (char_code == CH_LO_X || char_code == CH_UP_X)
						nxt.radix = RDX_16;
					else if (char_code == CH_LO_O || char_code == CH_UP_O)
						nxt.radix = RDX_8;
					else if (char_code == CH_LO_B || char_code == CH_UP_B)
						nxt.radix = RDX_2;
					else
						run_digit = 1'b1;
				end
				PH_DIGITS: run_digit = 1'b1;
				PH_SUFFIX: do_fail = 1'b1;
				PH_ERROR: ;
				default: ;
			endcase

			if (run_digit) begin
				nxt.phase = PH_DIGITS;
				nxt.radix = rdx;
				if (in_base) begin
					if (mul_ovf) begin
						do_fail   = 1'b1;
						fail_code = ST_OVERFLOW;
					end else begin
						nxt.acc = sum[63:0];
						if (sum[64]) begin
							do_fail   = 1'b1;
							fail_code = ST_OVERFLOW;
						end
					end
				end else if (suffix_ok) begin
					nxt.phase = PH_SUFFIX;
				end else begin
					do_fail = 1'b1;
				end
			end

			if (do_fail) begin
				nxt.phase = PH_ERROR;
				if (cur.err == ST_OK)
					nxt.err = fail_code;
			end
		end
	end

endmodule
